// ----- rtl/rtwi_pkg.sv -----
// Package with the shared types and constants of the reload timer.
`default_nettype none

package rtwi_pkg;

  // Width of the count and of the stored load value.
  localparam int unsigned CntW = 32;

  // Width of the register data bus.
  localparam int unsigned DataW = 32;

  // Control/status register layout.
  localparam int unsigned CsrModeLsb = 4;
  localparam int unsigned CsrFlagBit = 8;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdRead  = 2'd1,
    CmdWrite = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RegCsr   = 2'd0,
    RegLoad  = 2'd1,
    RegCount = 2'd2
  } reg_e;

  // Mode bits, most significant first, as they sit in the control/status register.
  typedef struct packed {
    logic enable;
    logic inten;
    logic load;
    logic autorld;
  } mode_t;

  // One request as it leaves the input register.
  typedef struct packed {
    logic [1:0]       command;
    logic [1:0]       register_index;
    logic [DataW-1:0] write_data;
  } req_t;

  // One result as it enters the result register.
  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             interrupt_line;
  } resp_t;

endpackage

`default_nettype wire

// ----- rtl/rtwi_if.sv -----
// Valid/ready channel interfaces for requests and results of the timer.
`default_nettype none

interface rtwi_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  register_index;
  logic [31:0] write_data;

  modport source (output valid, output command, output register_index,
                  output write_data, input ready);
  modport sink   (input valid, input command, input register_index,
                  input write_data, output ready);
endinterface

interface rtwi_resp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        interrupt_line;

  modport source (output valid, output read_data, output interrupt_line, input ready);
  modport sink   (input valid, input read_data, input interrupt_line, output ready);
endinterface

`default_nettype wire

// ----- rtl/rtwi_timer.sv -----
// Timer state and the combinational update that one request applies to it.
`default_nettype none

module rtwi_timer (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire rtwi_pkg::req_t req_i,
  output rtwi_pkg::resp_t     resp_o
);
  import rtwi_pkg::*;

  mode_t             mode_q, mode_d;
  logic              flag_q, flag_d;
  logic [CntW-1:0]   reload_q, reload_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [DataW-1:0]  rdata;
  logic              terminal;

  assign terminal = (count_q == {CntW{1'b1}});

  always_comb begin
    mode_d   = mode_q;
    flag_d   = flag_q;
    reload_d = reload_q;
    count_d  = count_q;
    rdata    = '0;
    case (req_i.command)
      CmdTick: begin
        if (mode_q.load) begin
          count_d = reload_q;
        end else if (mode_q.enable) begin
          if (terminal) begin
            flag_d = 1'b1;
            if (mode_q.autorld) begin
              count_d = reload_q;
            end else begin
              mode_d.enable = 1'b0;
            end
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      CmdRead: begin
        case (req_i.register_index)
          RegCsr: begin
            rdata[CsrFlagBit] = flag_q;
            rdata[CsrModeLsb +: 4] = mode_q;
          end
          RegLoad:  rdata = DataW'(reload_q);
          RegCount: rdata = DataW'(count_q);
          default:  rdata = '0;
        endcase
      end
      CmdWrite: begin
        case (req_i.register_index)
          RegCsr: begin
            mode_d = mode_t'(req_i.write_data[CsrModeLsb +: 4]);
            if (req_i.write_data[CsrFlagBit]) begin
              flag_d = 1'b0;
            end
          end
          RegLoad: reload_d = CntW'(req_i.write_data);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign resp_o.read_data      = rdata;
  assign resp_o.interrupt_line = flag_d & mode_d.inten;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      flag_q   <= 1'b0;
      reload_q <= '0;
      count_q  <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      flag_q   <= flag_d;
      reload_q <= reload_d;
      count_q  <= count_d;
    end
  end

  // The flag can only be raised by a tick that was applied in the previous cycle.
  a_flag_rise_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flag_q) |-> $past(fire_i && (req_i.command == CmdTick)))
    else $error("interrupt flag rose without a tick");

  // A held load bit pins the count to the load value on every tick.
  a_load_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (req_i.command == CmdTick) && mode_q.load |=> count_q == $past(reload_q))
    else $error("load tick did not copy the load value");

  // Register writes never move the count.
  a_write_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (req_i.command == CmdWrite) |=> $stable(count_q))
    else $error("register write changed the count");

  // Only reads return data.
  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (req_i.command != CmdRead) |-> resp_o.read_data == '0)
    else $error("non-read request returned data");

endmodule

`default_nettype wire

// ----- rtl/reload_timer_with_interrupt_unit.sv -----
// Top level of the auto-reload timer: input register, timer update, result register.
//
//  Channel  | Dir | Beat contents                              | Accepted when
//  ---------+-----+--------------------------------------------+-------------------
//  in_i     | in  | command, register_index, write_data        | valid && ready
//  out_o    | out | read_data, interrupt_line                  | valid && ready
//
// Each request beat lands in an input register. When the beat advances, the timer
// state is updated by one level of combinational logic (a 32-bit increment and an
// all-ones compare) and the result is captured in the result register.
// One beat per cycle is sustained; the block stalls only when the result register
// is full and the sink holds ready low, and then the input register holds its beat.
// Reset clears the timer state, the mode bits, the interrupt flag and both valids.
`default_nettype none

module reload_timer_with_interrupt_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rtwi_req_if.sink   in_i,
  rtwi_resp_if.source out_o
);
  import rtwi_pkg::*;

  // Input register stage.
  logic  req_valid_q;
  req_t  req_q;

  // Result register stage.
  logic  out_valid_q;
  resp_t out_q;

  resp_t resp;
  logic  advance;

  // The held request moves on when the result register is empty or being emptied.
  assign advance    = req_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      req_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_q.command        <= in_i.command;
      req_q.register_index <= in_i.register_index;
      req_q.write_data     <= in_i.write_data;
    end
  end

  // Timer state lives here; it only changes when a request advances.
  rtwi_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (req_q),
    .resp_o (resp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= resp;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.read_data      = out_q.read_data;
  assign out_o.interrupt_line = out_q.interrupt_line;

endmodule

`default_nettype wire
